// ===== src/spi_nor_flash_command_sequencer_unit_defines.svh =====
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfcs check failed");

// Next-cycle implication, checked outside reset.
`define SFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfcs check failed");

`endif

// ===== src/sfcs_pkg.sv =====
package sfcs_pkg;

  localparam int unsigned DefPageSize       = 256;
  localparam int unsigned DefSectorSize     = 4096;
  localparam int unsigned DefPowerDownTries = 10;
  localparam int unsigned MaxResults        = 16;

  // Host opcodes.
  localparam logic [2:0] OpOpen    = 3'd0;
  localparam logic [2:0] OpClose   = 3'd1;
  localparam logic [2:0] OpRead    = 3'd2;
  localparam logic [2:0] OpWrite   = 3'd3;
  localparam logic [2:0] OpErase   = 3'd4;
  localparam logic [2:0] OpPayload = 3'd5;
  localparam logic [2:0] OpRecv    = 3'd6;

  // Bus actions.
  localparam logic [2:0] ActSel     = 3'd0;
  localparam logic [2:0] ActRel     = 3'd1;
  localparam logic [2:0] ActSend    = 3'd2;
  localparam logic [2:0] ActRecv    = 3'd3;
  localparam logic [2:0] ActReq     = 3'd4;
  localparam logic [2:0] ActDeliver = 3'd5;
  localparam logic [2:0] ActDone    = 3'd6;

  // Flash instruction bytes.
  localparam logic [7:0] FlReadStatus = 8'h05;
  localparam logic [7:0] FlWriteEn    = 8'h06;
  localparam logic [7:0] FlProgram    = 8'h02;
  localparam logic [7:0] FlRead       = 8'h03;
  localparam logic [7:0] FlErase      = 8'h20;
  localparam logic [7:0] FlReadId     = 8'h90;
  localparam logic [7:0] FlPowerDown  = 8'hB9;
  localparam logic [7:0] FlWakeUp     = 8'hAB;

  // Register indexes.
  localparam logic [1:0] RegPresent = 2'd0;
  localparam logic [1:0] RegMaker   = 2'd1;
  localparam logic [1:0] RegDevice  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [23:0] offset;
    logic [24:0] length;
    logic [7:0]  data_byte;
    logic        bus_ok;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       success;
    logic       last;
  } out_t;

  typedef struct packed {
    out_t [MaxResults-1:0] e;
    logic [4:0]            n;
  } rlist_t;

  function automatic rlist_t emit(rlist_t l, logic [2:0] a, logic [7:0] v, logic ok);
    rlist_t r;
    r = l;
    if (r.n < 5'(MaxResults)) begin
      r.e[r.n[3:0]] = '{action: a, byte_value: v, success: ok, last: 1'b0};
      r.n = r.n + 5'd1;
    end
    return r;
  endfunction

  function automatic rlist_t send_addr(rlist_t l, logic [23:0] addr);
    rlist_t r;
    r = emit(l, ActSend, addr[23:16], 1'b0);
    r = emit(r, ActSend, addr[15:8], 1'b0);
    r = emit(r, ActSend, addr[7:0], 1'b0);
    return r;
  endfunction

  function automatic rlist_t poll(rlist_t l);
    rlist_t r;
    r = emit(l, ActSel, 8'h00, 1'b0);
    r = emit(r, ActSend, FlReadStatus, 1'b0);
    r = emit(r, ActRecv, 8'h00, 1'b0);
    return r;
  endfunction

  function automatic rlist_t id_read(rlist_t l);
    rlist_t r;
    r = emit(l, ActSel, 8'h00, 1'b0);
    r = emit(r, ActSend, FlReadId, 1'b0);
    r = emit(r, ActSend, 8'hFF, 1'b0);
    r = emit(r, ActSend, 8'hFF, 1'b0);
    r = emit(r, ActSend, 8'h00, 1'b0);
    r = emit(r, ActRecv, 8'h00, 1'b0);
    return r;
  endfunction

endpackage

// ===== src/sfcs_stream_if.sv =====
interface sfcs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ===== src/spi_nor_flash_command_sequencer_unit.sv =====
// Results of an accepted word are registered and appear from the next cycle, one word per
// cycle while res_o.ready is high; an input word causes at most 16 results, all drained in
// order through the single result port from the result buffer.
// The next input word is taken in the cycle its predecessor's last result is taken.
// Reset (rst_ni low, asynchronous) clears the sequencer state, empties the result buffer
// and loads the configuration registers with flash present and both ID bytes 0xFF.
module spi_nor_flash_command_sequencer_unit
  import sfcs_pkg::*;
#(
  parameter int unsigned PageSize       = DefPageSize,
  parameter int unsigned SectorSize     = DefSectorSize,
  parameter int unsigned PowerDownTries = DefPowerDownTries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfcs_stream_if.sink         cmd_i,
  sfcs_stream_if.source       res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned PW    = $clog2(PageSize);
  localparam int unsigned SW    = $clog2(SectorSize);
  localparam int unsigned SectW = 26 - SW;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhStatus  = 3'd1;
  localparam logic [2:0] PhRead    = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhId1     = 3'd4;
  localparam logic [2:0] PhId2     = 3'd5;

  // Configuration registers.
  logic       present_q;
  logic [7:0] maker_q, device_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b1;
      maker_q   <= 8'hFF;
      device_q  <= 8'hFF;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegPresent: present_q <= pwdata[0];
        RegMaker:   maker_q   <= pwdata[7:0];
        RegDevice:  device_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegPresent: prdata = {31'd0, present_q};
      RegMaker:   prdata = {24'd0, maker_q};
      RegDevice:  prdata = {24'd0, device_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Sequencer state.
  logic [2:0]       phase_q, phase_d;
  logic [2:0]       kind_q, kind_d;
  logic [23:0]      addr_q, addr_d;
  logic [24:0]      bytes_q, bytes_d;
  logic [PW:0]      page_q, page_d;
  logic [SectW-1:0] sect_q, sect_d;
  logic [7:0]       first_q, first_d;
  logic [3:0]       retry_q, retry_d;

  // Result buffer.
  out_t [MaxResults-1:0] res_q;
  logic [4:0]            n_q, idx_q;
  rlist_t                l;
  in_t                   in;
  logic                  cmd_acc, res_acc;

  assign in      = cmd_i.data;
  assign res_o.valid = (idx_q != n_q);
  assign res_o.data  = res_q[idx_q[3:0]];
  assign res_acc = res_o.valid && res_o.ready;
  assign cmd_i.ready = !res_o.valid || (res_o.ready && (idx_q == n_q - 5'd1));
  assign cmd_acc = cmd_i.valid && cmd_i.ready;

  // Next state and the result list of the offered word.
  always_comb begin
    logic [25:0]  sum;
    logic [PW:0]  room;
    logic [24:0]  bytes_new;
    logic [PW:0]  page_new;
    logic [SectW-1:0] sect_new;
    logic [3:0]   retry_new;
    logic         match;
    l = '0;
    phase_d = phase_q;
    kind_d  = kind_q;
    addr_d  = addr_q;
    bytes_d = bytes_q;
    page_d  = page_q;
    sect_d  = sect_q;
    first_d = first_q;
    retry_d = retry_q;
    sum = 26'(in.offset[SW-1:0]) + 26'(in.length) + 26'(SectorSize - 1);
    room = (PW+1)'(PageSize) - {1'b0, addr_q[PW-1:0]};
    bytes_new = (bytes_q != 25'd0) ? bytes_q - 25'd1 : bytes_q;
    page_new  = (page_q != '0) ? page_q - 1'b1 : page_q;
    sect_new  = (sect_q != '0) ? sect_q - 1'b1 : sect_q;
    retry_new = retry_q + 4'd1;
    match = (first_q == maker_q) && (in.data_byte == device_q);

    if (phase_q == PhIdle) begin
      if (in.opcode <= OpErase) kind_d = in.opcode;
      case (in.opcode)
        OpOpen: begin
          if (!present_q) begin
            l = emit(l, ActDone, 8'h00, 1'b0);
          end else begin
            l = emit(l, ActRel, 8'h00, 1'b0);
            l = emit(l, ActSel, 8'h00, 1'b0);
            l = emit(l, ActSend, FlWakeUp, 1'b0);
            l = emit(l, ActRel, 8'h00, 1'b0);
            l = poll(l);
            phase_d = PhStatus;
          end
        end
        OpClose: begin
          retry_d = 4'd0;
          l = poll(l);
          phase_d = PhStatus;
        end
        OpRead, OpWrite: begin
          addr_d  = in.offset;
          bytes_d = in.length;
          if (in.opcode == OpWrite && in.length == 25'd0) begin
            l = emit(l, ActDone, 8'h00, 1'b1);
          end else begin
            l = poll(l);
            phase_d = PhStatus;
          end
        end
        OpErase: begin
          if (in.length == 25'd0) begin
            l = emit(l, ActDone, 8'h00, 1'b1);
          end else begin
            addr_d = {in.offset[23:SW], SW'(0)};
            sect_d = SectW'(sum >> SW);
            l = poll(l);
            phase_d = PhStatus;
          end
        end
        default: ;
      endcase
    end else if (phase_q == PhPayload) begin
      if (in.opcode == OpPayload) begin
        l = emit(l, ActSend, in.data_byte, 1'b0);
        addr_d  = addr_q + 24'd1;
        bytes_d = bytes_new;
        page_d  = page_new;
        if (page_new != '0) begin
          l = emit(l, ActReq, 8'h00, 1'b0);
        end else begin
          l = emit(l, ActRel, 8'h00, 1'b0);
          if (bytes_new != 25'd0) begin
            l = poll(l);
            phase_d = PhStatus;
          end else begin
            l = emit(l, ActDone, 8'h00, 1'b1);
            phase_d = PhIdle;
          end
        end
      end
    end else if (in.opcode == OpRecv) begin
      if (!in.bus_ok) begin
        l = emit(l, ActRel, 8'h00, 1'b0);
        l = emit(l, ActDone, 8'h00, 1'b0);
        phase_d = PhIdle;
      end else if (phase_q == PhStatus) begin
        if (in.data_byte[0]) begin
          l = emit(l, ActRecv, 8'h00, 1'b0);
        end else begin
          // Flash idle: start the command proper.
          l = emit(l, ActRel, 8'h00, 1'b0);
          case (kind_q)
            OpOpen: begin
              l = id_read(l);
              phase_d = PhId1;
            end
            OpClose: begin
              l = emit(l, ActSel, 8'h00, 1'b0);
              l = emit(l, ActSend, FlPowerDown, 1'b0);
              l = emit(l, ActRel, 8'h00, 1'b0);
              retry_d = 4'd0;
              l = id_read(l);
              phase_d = PhId1;
            end
            OpRead: begin
              l = emit(l, ActSel, 8'h00, 1'b0);
              l = emit(l, ActSend, FlRead, 1'b0);
              l = send_addr(l, addr_q);
              if (bytes_q == 25'd0) begin
                l = emit(l, ActRel, 8'h00, 1'b0);
                l = emit(l, ActDone, 8'h00, 1'b1);
                phase_d = PhIdle;
              end else begin
                l = emit(l, ActRecv, 8'h00, 1'b0);
                phase_d = PhRead;
              end
            end
            OpWrite: begin
              l = emit(l, ActSel, 8'h00, 1'b0);
              l = emit(l, ActSend, FlWriteEn, 1'b0);
              l = emit(l, ActRel, 8'h00, 1'b0);
              l = emit(l, ActSel, 8'h00, 1'b0);
              l = emit(l, ActSend, FlProgram, 1'b0);
              l = send_addr(l, addr_q);
              page_d = (bytes_q < 25'(room)) ? bytes_q[PW:0] : room;
              l = emit(l, ActReq, 8'h00, 1'b0);
              phase_d = PhPayload;
            end
            OpErase: begin
              l = emit(l, ActSel, 8'h00, 1'b0);
              l = emit(l, ActSend, FlWriteEn, 1'b0);
              l = emit(l, ActRel, 8'h00, 1'b0);
              l = emit(l, ActSel, 8'h00, 1'b0);
              l = emit(l, ActSend, FlErase, 1'b0);
              l = send_addr(l, addr_q);
              l = emit(l, ActRel, 8'h00, 1'b0);
              addr_d = addr_q + 24'(SectorSize);
              sect_d = sect_new;
              if (sect_new != '0) begin
                l = poll(l);
                phase_d = PhStatus;
              end else begin
                l = emit(l, ActDone, 8'h00, 1'b1);
                phase_d = PhIdle;
              end
            end
            default: begin
              l = emit(l, ActDone, 8'h00, 1'b0);
              phase_d = PhIdle;
            end
          endcase
        end
      end else if (phase_q == PhRead) begin
        l = emit(l, ActDeliver, in.data_byte, 1'b0);
        addr_d  = addr_q + 24'd1;
        bytes_d = bytes_new;
        if (bytes_new == 25'd0) begin
          l = emit(l, ActRel, 8'h00, 1'b0);
          l = emit(l, ActDone, 8'h00, 1'b1);
          phase_d = PhIdle;
        end else begin
          l = emit(l, ActRecv, 8'h00, 1'b0);
        end
      end else if (phase_q == PhId1) begin
        first_d = in.data_byte;
        l = emit(l, ActRecv, 8'h00, 1'b0);
        phase_d = PhId2;
      end else if (phase_q == PhId2) begin
        l = emit(l, ActRel, 8'h00, 1'b0);
        if (kind_q == OpOpen) begin
          l = emit(l, ActDone, 8'h00, match);
          phase_d = PhIdle;
        end else if (!match) begin
          l = emit(l, ActDone, 8'h00, 1'b1);
          phase_d = PhIdle;
        end else begin
          // Flash still answers: power-down did not take yet.
          retry_d = retry_new;
          if (retry_new < 4'(PowerDownTries)) begin
            l = id_read(l);
            phase_d = PhId1;
          end else begin
            l = emit(l, ActDone, 8'h00, 1'b0);
            phase_d = PhIdle;
          end
        end
      end
    end

    // Mark the final word of the list.
    if (l.n != 5'd0) l.e[4'(l.n - 5'd1)].last = 1'b1;
  end

  // State and result counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      kind_q  <= 3'd0;
      addr_q  <= 24'd0;
      bytes_q <= 25'd0;
      page_q  <= '0;
      sect_q  <= '0;
      first_q <= 8'd0;
      retry_q <= 4'd0;
      n_q     <= 5'd0;
      idx_q   <= 5'd0;
    end else if (cmd_acc) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      bytes_q <= bytes_d;
      page_q  <= page_d;
      sect_q  <= sect_d;
      first_q <= first_d;
      retry_q <= retry_d;
      n_q     <= l.n;
      idx_q   <= 5'd0;
    end else if (res_acc) begin
      idx_q <= idx_q + 5'd1;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_acc) res_q <= l.e;
  end

endmodule

// ===== src/sfcs_checker.sv =====
`include "spi_nor_flash_command_sequencer_unit_defines.svh"

module sfcs_checker
  import sfcs_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  sfcs_stream_if.sink   cmd_i,
  sfcs_stream_if.source res_o,
  input logic           pready
);

  // A held result stays put until taken.
  `SFCS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_o.valid && !res_o.ready, res_o.valid && $stable(res_o.data))

  // A new word is taken only as the last pending result leaves.
  `SFCS_ASSERT_IMP(a_take_on_last, clk_i, rst_ni, cmd_i.ready && res_o.valid, res_o.ready && res_o.data.last)

  // Completion closes the result list of its word.
  `SFCS_ASSERT_IMP(a_done_last, clk_i, rst_ni, res_o.valid && res_o.data.action == ActDone, res_o.data.last)

  // Success is only reported with a completion.
  `SFCS_ASSERT_IMP(a_ok_done, clk_i, rst_ni, res_o.valid && res_o.data.success, res_o.data.action == ActDone && pready)

endmodule

bind spi_nor_flash_command_sequencer_unit sfcs_checker u_sfcs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cmd_i  (cmd_i),
  .res_o  (res_o),
  .pready (pready)
);
